// ----- src/stepper_position_stepper_defines.svh -----
// ----------------------------------------------------------------------------
// stepper_position_stepper_defines
// Assertion macros used by the checker file of the stepper block.
// ----------------------------------------------------------------------------
`ifndef STEPPER_POSITION_STEPPER_DEFINES_SVH
`define STEPPER_POSITION_STEPPER_DEFINES_SVH

// antecedent holds now, consequent holds in the same cycle
`define SPS_ASSERT_NOW(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error("%m: check failed");

// antecedent holds now, consequent holds in the next cycle
`define SPS_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error("%m: check failed");

`endif

// ----- src/sps_pkg.sv -----
// ----------------------------------------------------------------------------
// sps_pkg
// Types, widths and codes of the stepper position controller.
// ----------------------------------------------------------------------------
package sps_pkg;

   localparam int MAX_PHASES     = 8;
   localparam int POSITION_WIDTH = 32;

   localparam int PH_W      = $clog2(MAX_PHASES);
   localparam int CNT_W     = 4;
   localparam int PAT_W     = 8;
   localparam int TABLE_W   = 64;
   localparam int DB_W      = 16;
   localparam int LIM_W     = 32;
   localparam int FIELD_W   = 32;
   localparam int ACT_W     = 2;
   localparam int STAT_W    = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 64;
   localparam int REQ_USER_W = 8;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_USED_W = PAT_W + FIELD_W + STAT_W;
   localparam int RSP_DATA_W = ((RSP_USED_W + 7) / 8) * 8;

   localparam logic [ACT_W-1:0] ACT_TICK       = 2'd0;
   localparam logic [ACT_W-1:0] ACT_SET_TARGET = 2'd1;
   localparam logic [ACT_W-1:0] ACT_ZERO       = 2'd2;

   localparam logic [STAT_W-1:0] ST_HOLD    = 3'd0;
   localparam logic [STAT_W-1:0] ST_RIGHT   = 3'd1;
   localparam logic [STAT_W-1:0] ST_LEFT    = 3'd2;
   localparam logic [STAT_W-1:0] ST_BLOCKED = 3'd3;
   localparam logic [STAT_W-1:0] ST_SET     = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_LIMIT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_LIMIT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_COUNT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_TABLE = 3'd4;

   typedef struct packed {
      logic [DB_W-1:0]         deadband;
      logic signed [LIM_W-1:0] left_limit;
      logic signed [LIM_W-1:0] right_limit;
      logic [CNT_W-1:0]        phase_count;
      logic [TABLE_W-1:0]      phase_table;
   } cfg_type;

   typedef struct packed {
      logic [STAT_W-1:0]         status;
      logic signed [FIELD_W-1:0] position;
      logic [PAT_W-1:0]          coil_pattern;
   } res_type;

endpackage

// ----- src/sps_csr.sv -----
// ----------------------------------------------------------------------------
// sps_csr
// Configuration registers written through the plain write port.
// ----------------------------------------------------------------------------
module sps_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [sps_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sps_pkg::CSR_DAT_W-1:0]   csr_wdata,
   output sps_pkg::cfg_type                cfg
);
   import sps_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DEADBAND:    cfg_in.deadband    = csr_wdata[DB_W-1:0];
            CSR_LEFT_LIMIT:  cfg_in.left_limit  = csr_wdata[LIM_W-1:0];
            CSR_RIGHT_LIMIT: cfg_in.right_limit = csr_wdata[LIM_W-1:0];
            CSR_PHASE_COUNT: cfg_in.phase_count = csr_wdata[CNT_W-1:0];
            CSR_PHASE_TABLE: cfg_in.phase_table = csr_wdata[TABLE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deadband    <= '0;
         cfg_ff.left_limit  <= {1'b1, {(LIM_W-1){1'b0}}};
         cfg_ff.right_limit <= {1'b0, {(LIM_W-1){1'b1}}};
         cfg_ff.phase_count <= CNT_W'(4);
         cfg_ff.phase_table <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- src/sps_step.sv -----
// ----------------------------------------------------------------------------
// sps_step
// Input register, position/target/phase state and the single-pass step logic.
// ----------------------------------------------------------------------------
module sps_step (
   input  logic                               clock,
   input  logic                               reset,
   input  sps_pkg::cfg_type                   cfg,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sps_pkg::ACT_W-1:0]          req_action,
   input  logic [sps_pkg::FIELD_W-1:0]        req_target,
   input  logic                               out_free,
   output logic                               res_valid,
   output sps_pkg::res_type                   res
);
   import sps_pkg::*;

   localparam int POS_W = POSITION_WIDTH;
   localparam int DIF_W = POS_W + 1;
   localparam int CMP_W = (DIF_W > DB_W) ? DIF_W : DB_W;
   localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

   logic                      in_valid_ff, in_valid_in;
   logic [ACT_W-1:0]          in_action_ff;
   logic [POS_W-1:0]          in_target_ff;
   logic signed [POS_W-1:0]   pos_ff, pos_in;
   logic signed [POS_W-1:0]   tgt_ff, tgt_in;
   logic [PH_W-1:0]           phase_ff, phase_in;

   logic                      adv;
   logic                      take;
   logic [CNT_W-1:0]          eff_count;
   logic [PH_W-1:0]           last_phase;
   logic [CNT_W-1:0]          phase_up;
   logic signed [DIF_W-1:0]   diff;
   logic [DIF_W-1:0]          mag;
   logic signed [LIM_W-1:0]   pos_ext;
   logic [STAT_W-1:0]         status;
   logic [PH_W+2:0]           pat_base;

   assign adv        = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      if (take) begin
         in_valid_in = 1'b1;
      end else if (adv) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_action_ff <= req_action;
         in_target_ff <= req_target[POS_W-1:0];
      end
   end

   always_comb begin
      if (cfg.phase_count == '0) begin
         eff_count = CNT_W'(1);
      end else if (cfg.phase_count > CNT_W'(MAX_PHASES)) begin
         eff_count = CNT_W'(MAX_PHASES);
      end else begin
         eff_count = cfg.phase_count;
      end
   end

   assign last_phase = PH_W'(eff_count - CNT_W'(1));
   assign phase_up   = CNT_W'(phase_ff) + CNT_W'(1);
   assign diff       = DIF_W'(pos_ff) - DIF_W'(tgt_ff);
   assign mag        = diff[DIF_W-1] ? DIF_W'(-diff) : DIF_W'(diff);
   assign pos_ext    = LIM_W'(pos_ff);

   always_comb begin
      pos_in   = pos_ff;
      tgt_in   = tgt_ff;
      phase_in = phase_ff;
      status   = ST_HOLD;
      case (in_action_ff)
         ACT_SET_TARGET: begin
            tgt_in = in_target_ff;
            status = ST_SET;
         end
         ACT_ZERO: begin
            tgt_in = '0;
            pos_in = '0;
            status = ST_SET;
         end
         ACT_TICK: begin
            if (CMP_W'(mag) <= CMP_W'(cfg.deadband)) begin
               status = ST_HOLD;
            end else if (diff > 0) begin
               if (pos_ext < cfg.left_limit || pos_ff == POS_MIN) begin
                  status = ST_BLOCKED;
               end else begin
                  phase_in = (phase_ff == '0) ? last_phase : phase_ff - PH_W'(1);
                  pos_in   = pos_ff - POS_W'(1);
                  status   = ST_LEFT;
               end
            end else begin
               if (pos_ext > cfg.right_limit || pos_ff == POS_MAX) begin
                  status = ST_BLOCKED;
               end else begin
                  phase_in = (phase_up >= eff_count) ? '0 : phase_up[PH_W-1:0];
                  pos_in   = pos_ff + POS_W'(1);
                  status   = ST_RIGHT;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         tgt_ff   <= '0;
         phase_ff <= '0;
      end else if (adv) begin
         pos_ff   <= pos_in;
         tgt_ff   <= tgt_in;
         phase_ff <= phase_in;
      end
   end

   assign pat_base = {phase_in, 3'b000};

   assign res_valid        = adv;
   assign res.coil_pattern = cfg.phase_table[pat_base +: PAT_W];
   assign res.position     = FIELD_W'(pos_in);
   assign res.status       = status;

endmodule

// ----- src/sps_rsp.sv -----
// ----------------------------------------------------------------------------
// sps_rsp
// Result register holding one word for the result channel.
// ----------------------------------------------------------------------------
module sps_rsp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 res_valid,
   input  sps_pkg::res_type                     res,
   output logic                                 out_free,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [sps_pkg::RSP_DATA_W-1:0]       rsp_tdata
);
   import sps_pkg::*;

   logic    valid_ff, valid_in;
   res_type data_ff;

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      if (res_valid) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         data_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(data_ff);

endmodule

// ----- src/stepper_position_stepper.sv -----
// ----------------------------------------------------------------------------
// stepper_position_stepper
// Stepper motor position controller, one result word per request word.
// ----------------------------------------------------------------------------
// Requests enter on req_* (action in tuser, target in tdata). A tick compares
// the position with the target and steps one phase toward it unless inside
// the deadband or past a limit; the other actions set the target or zero it
// together with the position. Each request yields exactly one word on rsp_*
// carrying coil pattern, position and status.
// Path: an accepted request is held in the input register, then its result
// word is written into the result register, which drives rsp_tvalid.
// Throughput: one word per cycle while rsp_tready stays high; the state update
// is a subtract, a compare and a table select between those two registers.
// When rsp_tready is low the result word holds and the input register keeps
// one more word; req_tready then drops until the result is taken.
// Reset clears position, target and phase index, loads the register reset
// values and empties both stages. Configuration is written through csr_*
// only while no request is in flight: a rule for the user, unenforced here.
// ----------------------------------------------------------------------------
module stepper_position_stepper (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [31:0] target_position
   input  logic [sps_pkg::REQ_DATA_W-1:0]       req_tdata,
   // [1:0] action
   input  logic [sps_pkg::REQ_USER_W-1:0]       req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [7:0] coil_pattern, [39:8] position, [42:40] status
   output logic [sps_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  logic                                 csr_we,
   input  logic [sps_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [sps_pkg::CSR_DAT_W-1:0]        csr_wdata
);
   import sps_pkg::*;

   cfg_type cfg;
   res_type res;
   logic    res_valid;
   logic    out_free;

   sps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sps_step u_step (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser[ACT_W-1:0]),
      .req_target (req_tdata[FIELD_W-1:0]),
      .out_free   (out_free),
      .res_valid  (res_valid),
      .res        (res)
   );

   sps_rsp u_rsp (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res        (res),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- src/sps_checker.sv -----
// ----------------------------------------------------------------------------
// sps_checker
// Port-level checks of the stepper controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "stepper_position_stepper_defines.svh"

module sps_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic [sps_pkg::RSP_DATA_W-1:0]       rsp_tdata
);
   import sps_pkg::*;

   `SPS_ASSERT_NEXT(a_rsp_hold, clock, !reset && rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `SPS_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_tvalid && req_tready)
   `SPS_ASSERT_NOW(a_pad_zero, clock, !reset && rsp_tvalid, rsp_tdata[RSP_DATA_W-1:RSP_USED_W] == '0)
   `SPS_ASSERT_NEXT(a_no_phantom, clock,
      !reset && !rsp_tvalid && !$past(req_tvalid && req_tready), !rsp_tvalid)

endmodule

bind stepper_position_stepper sps_checker u_sps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
